[rtl/brmq_pkg.sv]
// brmq_pkg: shared constants, types and helpers of the block range minimum query core
// no dependencies; used by the interfaces and the top level
`timescale 1ns / 1ps

package brmq_pkg;

  // sizes
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned LenW        = 3;
  localparam int unsigned LvlW        = 4;
  localparam int unsigned SparseLvls  = 11;
  localparam int unsigned SparseDepth = SparseLvls * MaxElements;
  localparam int unsigned SpAddrW     = LvlW + IdxW;

  // opcodes of an input word
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // reply kinds and status codes
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_BAD   = 1'b1;

  typedef logic [IdxW-1:0]          idx_t;
  typedef logic [CntW-1:0]          cnt_t;
  typedef logic signed [ValueW-1:0] val_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_CMP,
    S_PK_BMA,
    S_PK_BMC,
    S_PK_ELA,
    S_PK_ELC,
    S_PK_END,
    S_B_NEXT,
    S_B_BMW,
    S_B_LVL,
    S_B_LOOP,
    S_B_SPA,
    S_B_SPC,
    S_B_SPW,
    S_B_SPWR,
    S_Q_DIV,
    S_Q_SPLIT,
    S_Q_MID,
    S_Q_TA,
    S_Q_TC,
    S_Q_TW,
    S_Q_CBM,
    S_Q_CEL,
    S_Q_CCMP,
    S_Q_SC2,
    S_Q_DONE,
    S_OUT
  } state_e;

  // index divided by a block length of one to five, by shift or reciprocal multiply
  function automatic idx_t div_by_len(idx_t x, logic [LenW-1:0] k);
    logic [20:0] p3;
    logic [20:0] p5;
    idx_t        r;
    p3 = 21'(x) * 21'd683;
    p5 = 21'(x) * 21'd1639;
    unique case (k)
      3'd2:    r = x >> 1;
      3'd3:    r = p3[20:11];
      3'd4:    r = x >> 2;
      3'd5:    r = 10'(p5 >> 13);
      default: r = x;
    endcase
    return r;
  endfunction

  // floor of log2 for a nonzero span
  function automatic logic [LvlW-1:0] floor_log2(idx_t x);
    logic [LvlW-1:0] r;
    r = '0;
    for (int i = 0; i < IdxW; i++) begin
      if (x[i]) r = LvlW'(i);
    end
    return r;
  endfunction

  // smallest block length k >= 1 with 4^k >= n
  function automatic logic [LenW-1:0] len_for(cnt_t n);
    logic [LenW-1:0] k;
    if (n <= 11'd4)        k = 3'd1;
    else if (n <= 11'd16)  k = 3'd2;
    else if (n <= 11'd64)  k = 3'd3;
    else if (n <= 11'd256) k = 3'd4;
    else                   k = 3'd5;
    return k;
  endfunction

endpackage

[rtl/brmq_if.sv]
// brmq_if: handshake channels of the range minimum query core
// depends on brmq_pkg for field types
`timescale 1ns / 1ps

// input word channel
interface brmq_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  brmq_pkg::idx_t          left_index;
  brmq_pkg::idx_t          right_index;
  brmq_pkg::val_t          element_value;
  modport source (output valid, opcode, left_index, right_index, element_value, input ready);
  modport sink   (input valid, opcode, left_index, right_index, element_value, output ready);
endinterface

// reply word channel
interface brmq_out_if;
  logic                    valid;
  logic                    ready;
  logic                    reply_kind;
  brmq_pkg::idx_t          min_position;
  brmq_pkg::val_t          min_value;
  logic                    status;
  modport source (output valid, reply_kind, min_position, min_value, status, input ready);
  modport sink   (input valid, reply_kind, min_position, min_value, status, output ready);
endinterface

// element count register write channel
interface brmq_cfg_if;
  logic                    valid;
  logic                    ready;
  brmq_pkg::cnt_t          element_count;
  modport source (output valid, element_count, input ready);
  modport sink   (input valid, element_count, output ready);
endinterface

[rtl/brmq_ram.sv]
// brmq_ram: generic single write, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module brmq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/block_range_minimum_query_core.sv]
// Range minimum query core: one word at a time, the input stalls until the reply is handed over.
// Words: a write goes to the element ram on acceptance; a bad-range query goes straight to the reply;
// a good query scans its elements in the end blocks (at most ten) and reads the sparse table for full blocks between.
// Build: scans each block for its minimum, then fills the sparse table level by level, entry by entry.
// Every memory read is synchronous with registered data; a held reply adds its stall.
// Reset clears control state only; the memories keep contents and need no clearing pass.
`timescale 1ns / 1ps

module block_range_minimum_query_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  brmq_in_if.sink     in_i,
  brmq_cfg_if.sink    cfg_i,
  brmq_out_if.source  out_o
);

  // registers
  brmq_pkg::state_e               state_q, state_d, ret_q, ret_d;
  brmq_pkg::cnt_t                 ec_q, ec_d, bcnt_q, bcnt_d, btot_q, btot_d;
  logic [brmq_pkg::LenW-1:0]      blen_q, blen_d;
  brmq_pkg::idx_t                 li_q, li_d, ri_q, ri_d;
  brmq_pkg::idx_t                 sc_cur_q, sc_cur_d, sc_hi_q, sc_hi_d;
  brmq_pkg::idx_t                 best_pos_q, best_pos_d;
  brmq_pkg::val_t                 best_val_q, best_val_d;
  logic                           best_vld_q, best_vld_d;
  brmq_pkg::idx_t                 pa_q, pa_d, pc_q, pc_d, ppa_q, ppa_d, ppc_q, ppc_d;
  brmq_pkg::val_t                 pva_q, pva_d;
  brmq_pkg::idx_t                 pk_q, pk_d;
  brmq_pkg::cnt_t                 bstart_q, bstart_d, bidx_q, bidx_d;
  logic [brmq_pkg::LvlW-1:0]      lv_q, lv_d, qlv_q, qlv_d;
  brmq_pkg::idx_t                 bi_q, bi_d, bj_q, bj_d, tlo_q, tlo_d, thi_q, thi_d;
  brmq_pkg::idx_t                 cand_q, cand_d;
  logic                           rep_kind_q, rep_kind_d, rep_bad_q, rep_bad_d;
  logic                           out_vld_q, out_vld_d;
  logic                           out_kind_q, out_kind_d, out_st_q, out_st_d;
  brmq_pkg::idx_t                 out_pos_q, out_pos_d;
  brmq_pkg::val_t                 out_val_q, out_val_d;

  // memory ports
  logic                           el_we, bm_we, sp_we;
  brmq_pkg::idx_t                 el_waddr, el_raddr, bm_waddr, bm_raddr;
  logic [brmq_pkg::ValueW-1:0]    el_wdata, el_rdata;
  brmq_pkg::idx_t                 bm_wdata, bm_rdata, sp_wdata, sp_rdata;
  logic [brmq_pkg::SpAddrW-1:0]   sp_waddr, sp_raddr;

  // combinational helpers
  logic                           in_acc;
  brmq_pkg::cnt_t                 n_clamp, blk_end;
  logic [13:0]                    mul_tmp;
  brmq_pkg::val_t                 el_val;
  brmq_pkg::idx_t                 span;
  logic [brmq_pkg::LvlW-1:0]      span_lv;
  logic [11:0]                    lvl_size;
  brmq_pkg::idx_t                 half;

  brmq_ram #(.DEPTH(brmq_pkg::MaxElements), .WIDTH(brmq_pkg::ValueW)) u_elem_ram (
    .clk_i, .we_i(el_we), .waddr_i(el_waddr), .wdata_i(el_wdata),
    .raddr_i(el_raddr), .rdata_o(el_rdata)
  );

  brmq_ram #(.DEPTH(brmq_pkg::MaxElements), .WIDTH(brmq_pkg::IdxW)) u_bmin_ram (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

  brmq_ram #(.DEPTH(brmq_pkg::SparseDepth), .WIDTH(brmq_pkg::IdxW)) u_sparse_ram (
    .clk_i, .we_i(sp_we), .waddr_i(sp_waddr), .wdata_i(sp_wdata),
    .raddr_i(sp_raddr), .rdata_o(sp_rdata)
  );

  // handshakes
  assign in_acc       = in_i.valid & in_i.ready;
  assign in_i.ready   = (state_q == brmq_pkg::S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid        = out_vld_q;
  assign out_o.reply_kind   = out_kind_q;
  assign out_o.min_position = out_pos_q;
  assign out_o.min_value    = out_val_q;
  assign out_o.status       = out_st_q;

  assign el_val   = $signed(el_rdata);
  assign lvl_size = 12'd1 << lv_q;
  assign half     = 10'd1 << (lv_q - 4'd1);
  assign span     = bj_q - bi_q - 10'd1;
  assign span_lv  = brmq_pkg::floor_log2(span);

  // clamped element count for a build
  always_comb begin
    if (ec_q == '0) n_clamp = 11'd1;
    else if (ec_q > 11'(brmq_pkg::MaxElements)) n_clamp = 11'(brmq_pkg::MaxElements);
    else n_clamp = ec_q;
  end

  // sequencer: next state, datapath and memory control
  always_comb begin
    state_d = state_q;    ret_d = ret_q;
    ec_d = ec_q;          bcnt_d = bcnt_q;     btot_d = btot_q;   blen_d = blen_q;
    li_d = li_q;          ri_d = ri_q;
    sc_cur_d = sc_cur_q;  sc_hi_d = sc_hi_q;
    best_pos_d = best_pos_q; best_val_d = best_val_q; best_vld_d = best_vld_q;
    pa_d = pa_q; pc_d = pc_q; ppa_d = ppa_q; ppc_d = ppc_q; pva_d = pva_q; pk_d = pk_q;
    bstart_d = bstart_q;  bidx_d = bidx_q;     lv_d = lv_q;       qlv_d = qlv_q;
    bi_d = bi_q; bj_d = bj_q; tlo_d = tlo_q; thi_d = thi_q; cand_d = cand_q;
    rep_kind_d = rep_kind_q; rep_bad_d = rep_bad_q;
    out_vld_d  = out_vld_q & ~out_o.ready;
    out_kind_d = out_kind_q; out_st_d = out_st_q; out_pos_d = out_pos_q; out_val_d = out_val_q;
    el_we = 1'b0; el_waddr = in_i.left_index; el_wdata = in_i.element_value;
    el_raddr = sc_cur_q;
    bm_we = 1'b0; bm_waddr = bidx_q[9:0]; bm_wdata = best_pos_q; bm_raddr = pa_q;
    sp_we = 1'b0; sp_waddr = {lv_q, bidx_q[9:0]}; sp_wdata = pk_q;
    sp_raddr = {qlv_q, tlo_q};
    blk_end = bstart_q + 11'(blen_q);
    mul_tmp = '0;

    if (cfg_i.valid) ec_d = cfg_i.element_count;

    unique case (state_q)
      brmq_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.opcode)
            brmq_pkg::OP_WRITE: el_we = 1'b1;
            brmq_pkg::OP_BUILD: begin
              bcnt_d   = n_clamp;
              blen_d   = brmq_pkg::len_for(n_clamp);
              bstart_d = '0;
              bidx_d   = '0;
              state_d  = brmq_pkg::S_B_NEXT;
            end
            brmq_pkg::OP_QUERY: begin
              li_d = in_i.left_index;
              ri_d = in_i.right_index;
              if (in_i.left_index > in_i.right_index ||
                  11'(in_i.right_index) >= ec_q || 11'(in_i.right_index) >= bcnt_q) begin
                rep_kind_d = brmq_pkg::KIND_QUERY;
                rep_bad_d  = brmq_pkg::STAT_BAD;
                state_d    = brmq_pkg::S_OUT;
              end else begin
                state_d = brmq_pkg::S_Q_DIV;
              end
            end
            default: ;
          endcase
        end
      end

      // scan of elements sc_cur..sc_hi into the running best
      brmq_pkg::S_SC_RD: begin
        el_raddr = sc_cur_q;
        state_d  = brmq_pkg::S_SC_CMP;
      end
      brmq_pkg::S_SC_CMP: begin
        if (!best_vld_q || el_val < best_val_q) begin
          best_pos_d = sc_cur_q;
          best_val_d = el_val;
          best_vld_d = 1'b1;
        end
        if (sc_cur_q == sc_hi_q) begin
          state_d = ret_q;
        end else begin
          sc_cur_d = sc_cur_q + 10'd1;
          state_d  = brmq_pkg::S_SC_RD;
        end
      end

      // pick of two blocks pa/pc by the current values of their minima
      brmq_pkg::S_PK_BMA: begin
        bm_raddr = pa_q;
        state_d  = brmq_pkg::S_PK_BMC;
      end
      brmq_pkg::S_PK_BMC: begin
        bm_raddr = pc_q;
        ppa_d    = bm_rdata;
        state_d  = brmq_pkg::S_PK_ELA;
      end
      brmq_pkg::S_PK_ELA: begin
        el_raddr = ppa_q;
        ppc_d    = bm_rdata;
        state_d  = brmq_pkg::S_PK_ELC;
      end
      brmq_pkg::S_PK_ELC: begin
        el_raddr = ppc_q;
        pva_d    = el_val;
        state_d  = brmq_pkg::S_PK_END;
      end
      brmq_pkg::S_PK_END: begin
        pk_d    = (el_val < pva_q) ? pc_q : pa_q;
        state_d = ret_q;
      end

      // build: block minima
      brmq_pkg::S_B_NEXT: begin
        if (bstart_q < bcnt_q) begin
          sc_cur_d   = bstart_q[9:0];
          sc_hi_d    = 10'(((blk_end > bcnt_q) ? bcnt_q : blk_end) - 11'd1);
          best_vld_d = 1'b0;
          ret_d      = brmq_pkg::S_B_BMW;
          state_d    = brmq_pkg::S_SC_RD;
        end else begin
          btot_d  = bidx_q;
          lv_d    = 4'd1;
          state_d = brmq_pkg::S_B_LVL;
        end
      end
      brmq_pkg::S_B_BMW: begin
        bm_we    = 1'b1;
        bm_waddr = bidx_q[9:0];
        bm_wdata = best_pos_q;
        sp_we    = 1'b1;
        sp_waddr = {4'd0, bidx_q[9:0]};
        sp_wdata = bidx_q[9:0];
        bidx_d   = bidx_q + 11'd1;
        bstart_d = blk_end;
        state_d  = brmq_pkg::S_B_NEXT;
      end

      // build: sparse table levels
      brmq_pkg::S_B_LVL: begin
        if (lvl_size <= 12'(btot_q)) begin
          bidx_d  = '0;
          state_d = brmq_pkg::S_B_LOOP;
        end else begin
          rep_kind_d = brmq_pkg::KIND_BUILD;
          rep_bad_d  = brmq_pkg::STAT_OK;
          state_d    = brmq_pkg::S_OUT;
        end
      end
      brmq_pkg::S_B_LOOP: begin
        if (12'(bidx_q) + lvl_size <= 12'(btot_q)) begin
          state_d = brmq_pkg::S_B_SPA;
        end else begin
          lv_d    = lv_q + 4'd1;
          state_d = brmq_pkg::S_B_LVL;
        end
      end
      brmq_pkg::S_B_SPA: begin
        sp_raddr = {lv_q - 4'd1, bidx_q[9:0]};
        state_d  = brmq_pkg::S_B_SPC;
      end
      brmq_pkg::S_B_SPC: begin
        sp_raddr = {lv_q - 4'd1, bidx_q[9:0] + half};
        pa_d     = sp_rdata;
        state_d  = brmq_pkg::S_B_SPW;
      end
      brmq_pkg::S_B_SPW: begin
        pc_d    = sp_rdata;
        ret_d   = brmq_pkg::S_B_SPWR;
        state_d = brmq_pkg::S_PK_BMA;
      end
      brmq_pkg::S_B_SPWR: begin
        sp_we    = 1'b1;
        sp_waddr = {lv_q, bidx_q[9:0]};
        sp_wdata = pk_q;
        bidx_d   = bidx_q + 11'd1;
        state_d  = brmq_pkg::S_B_LOOP;
      end

      // query: block indices of both bounds
      brmq_pkg::S_Q_DIV: begin
        bi_d    = brmq_pkg::div_by_len(li_q, blen_q);
        bj_d    = brmq_pkg::div_by_len(ri_q, blen_q);
        state_d = brmq_pkg::S_Q_SPLIT;
      end
      brmq_pkg::S_Q_SPLIT: begin
        best_vld_d = 1'b0;
        sc_cur_d   = li_q;
        state_d    = brmq_pkg::S_SC_RD;
        if (bi_q == bj_q) begin
          sc_hi_d = ri_q;
          ret_d   = brmq_pkg::S_Q_DONE;
        end else begin
          mul_tmp = (14'(bi_q) + 14'd1) * 14'(blen_q) - 14'd1;
          sc_hi_d = mul_tmp[9:0];
          ret_d   = brmq_pkg::S_Q_MID;
        end
      end
      brmq_pkg::S_Q_MID: begin
        if (11'(bi_q) + 11'd1 < 11'(bj_q)) begin
          qlv_d   = span_lv;
          tlo_d   = bi_q + 10'd1;
          thi_d   = bj_q - (10'd1 << span_lv);
          state_d = brmq_pkg::S_Q_TA;
        end else begin
          state_d = brmq_pkg::S_Q_SC2;
        end
      end
      brmq_pkg::S_Q_TA: begin
        sp_raddr = {qlv_q, tlo_q};
        state_d  = brmq_pkg::S_Q_TC;
      end
      brmq_pkg::S_Q_TC: begin
        sp_raddr = {qlv_q, thi_q};
        pa_d     = sp_rdata;
        state_d  = brmq_pkg::S_Q_TW;
      end
      brmq_pkg::S_Q_TW: begin
        pc_d    = sp_rdata;
        ret_d   = brmq_pkg::S_Q_CBM;
        state_d = brmq_pkg::S_PK_BMA;
      end
      brmq_pkg::S_Q_CBM: begin
        bm_raddr = pk_q;
        state_d  = brmq_pkg::S_Q_CEL;
      end
      brmq_pkg::S_Q_CEL: begin
        el_raddr = bm_rdata;
        cand_d   = bm_rdata;
        state_d  = brmq_pkg::S_Q_CCMP;
      end
      brmq_pkg::S_Q_CCMP: begin
        if (el_val < best_val_q) begin
          best_pos_d = cand_q;
          best_val_d = el_val;
        end
        state_d = brmq_pkg::S_Q_SC2;
      end
      brmq_pkg::S_Q_SC2: begin
        mul_tmp  = 14'(bj_q) * 14'(blen_q);
        sc_cur_d = mul_tmp[9:0];
        sc_hi_d  = ri_q;
        ret_d    = brmq_pkg::S_Q_DONE;
        state_d  = brmq_pkg::S_SC_RD;
      end
      brmq_pkg::S_Q_DONE: begin
        rep_kind_d = brmq_pkg::KIND_QUERY;
        rep_bad_d  = brmq_pkg::STAT_OK;
        state_d    = brmq_pkg::S_OUT;
      end

      // hand the reply to the output register once it is free
      brmq_pkg::S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_kind_d = rep_kind_q;
          out_st_d   = rep_bad_q;
          if (rep_kind_q == brmq_pkg::KIND_QUERY && rep_bad_q == brmq_pkg::STAT_OK) begin
            out_pos_d = best_pos_q;
            out_val_d = best_val_q;
          end else begin
            out_pos_d = '0;
            out_val_d = '0;
          end
          state_d = brmq_pkg::S_IDLE;
        end
      end

      default: state_d = brmq_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brmq_pkg::S_IDLE;
      ret_q     <= brmq_pkg::S_IDLE;
      ec_q      <= 11'(brmq_pkg::MaxElements);
      bcnt_q    <= '0;
      btot_q    <= '0;
      blen_q    <= 3'd1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      ec_q      <= ec_d;
      bcnt_q    <= bcnt_d;
      btot_q    <= btot_d;
      blen_q    <= blen_d;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    li_q <= li_d;           ri_q <= ri_d;
    sc_cur_q <= sc_cur_d;   sc_hi_q <= sc_hi_d;
    best_pos_q <= best_pos_d; best_val_q <= best_val_d; best_vld_q <= best_vld_d;
    pa_q <= pa_d; pc_q <= pc_d; ppa_q <= ppa_d; ppc_q <= ppc_d; pva_q <= pva_d; pk_q <= pk_d;
    bstart_q <= bstart_d;   bidx_q <= bidx_d;   lv_q <= lv_d;   qlv_q <= qlv_d;
    bi_q <= bi_d; bj_q <= bj_d; tlo_q <= tlo_d; thi_q <= thi_d; cand_q <= cand_d;
    rep_kind_q <= rep_kind_d; rep_bad_q <= rep_bad_d;
    out_kind_q <= out_kind_d; out_st_q <= out_st_d;
    out_pos_q  <= out_pos_d;  out_val_q <= out_val_d;
  end

endmodule
